@@ hw/rtl/tbbs_pkg.sv @@
// Shared constants and types for the two-wire bit-banged serializer.
package tbbs_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int HOLD_W        = 3;
	localparam int SEG_IDX_W     = 5;

	localparam logic [HOLD_W-1:0] IDLE_UNITS = HOLD_W'(5);
	localparam logic [HOLD_W-1:0] STOP_UNITS = HOLD_W'(2);
	localparam logic [HOLD_W-1:0] UNIT_ONE   = HOLD_W'(1);
	localparam logic [HOLD_W-1:0] HOLD_FINAL = HOLD_W'(0);

	// Segment positions within the full sequence of one byte
	localparam logic [SEG_IDX_W-1:0] SEG_START_IDLE = SEG_IDX_W'(0);
	localparam logic [SEG_IDX_W-1:0] SEG_START_DATA = SEG_IDX_W'(1);
	localparam logic [SEG_IDX_W-1:0] SEG_START_CLK  = SEG_IDX_W'(2);
	localparam logic [SEG_IDX_W-1:0] SEG_BIT_FIRST  = SEG_IDX_W'(3);
	localparam logic [SEG_IDX_W-1:0] SEG_BIT_LAST   = SEG_IDX_W'(18);
	localparam logic [SEG_IDX_W-1:0] SEG_STOP_LOW   = SEG_IDX_W'(19);
	localparam logic [SEG_IDX_W-1:0] SEG_STOP_HIGH  = SEG_IDX_W'(20);
	localparam logic [SEG_IDX_W-1:0] SEG_END_LOW    = SEG_IDX_W'(21);
	localparam logic [SEG_IDX_W-1:0] SEG_END_CLK    = SEG_IDX_W'(22);
	localparam logic [SEG_IDX_W-1:0] SEG_END_IDLE   = SEG_IDX_W'(23);

	typedef struct packed {
		logic              clock_level;
		logic              data_level;
		logic [HOLD_W-1:0] hold_units;
	} seg_t;

endpackage

@@ hw/rtl/two_wire_bit_bang_serializer.sv @@
// Top level: turns message bytes into timed clock/data line segments.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------------
//  in      | in_valid / in_stall  | data_byte[7:0], end_of_message
//  out     | out_valid / out_stall| clock_level, data_level, hold_units[2:0], last_segment
//
// One segment leaves per cycle unless the output stalls; a byte has 18 segments,
// 21 with the start or the end sequence, 24 with both, as the segment counter sets.
// The next byte is taken in the cycle its predecessor's last segment moves to the
// output register, so bytes follow without a gap cycle.
// Reset clears the work and output valid flags and closes the message.
// A stall on the output holds the output register and freezes the segment counter.
module two_wire_bit_bang_serializer import tbbs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [BITS_PER_BYTE-1:0] data_byte,
	input  logic                     end_of_message,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     clock_level,
	output logic                     data_level,
	output logic [HOLD_W-1:0]        hold_units,
	output logic                     last_segment
);

	logic                     busy_q;
	logic                     frame_open_q;
	logic [BITS_PER_BYTE-1:0] byte_q;
	logic                     eom_q;
	logic [SEG_IDX_W-1:0]     seg_q;
	logic                     out_valid_q;
	seg_t                     out_seg_q;
	logic                     out_last_q;

	logic                     advance;
	logic                     seg_last;
	logic                     seg_done;
	logic                     in_acc;
	logic [SEG_IDX_W-1:0]     last_idx;
	seg_t                     seg;

	tbbs_seg_dec u_seg_dec (
		.seg_idx   (seg_q),
		.data_byte (byte_q),
		.seg       (seg)
	);

	assign last_idx = eom_q ? SEG_END_IDLE : SEG_STOP_HIGH;
	assign seg_last = (seg_q == last_idx);
	assign advance  = busy_q && (!out_valid_q || !out_stall);
	assign seg_done = advance && seg_last;
	assign in_stall = busy_q && !seg_done;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			frame_open_q <= 1'b0;
			seg_q        <= SEG_START_IDLE;
		end else if (in_acc) begin
			busy_q       <= 1'b1;
			// skip the start sequence inside an open message
			seg_q        <= frame_open_q ? SEG_BIT_FIRST : SEG_START_IDLE;
			frame_open_q <= !end_of_message;
		end else if (seg_done) begin
			busy_q <= 1'b0;
		end else if (advance) begin
			seg_q <= seg_q + SEG_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_q <= data_byte;
			eom_q  <= end_of_message;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_seg_q  <= seg;
			out_last_q <= seg_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign clock_level  = out_seg_q.clock_level;
	assign data_level   = out_seg_q.data_level;
	assign hold_units   = out_seg_q.hold_units;
	assign last_segment = out_last_q;

endmodule

@@ hw/rtl/tbbs_seg_dec.sv @@
// Segment decoder: line levels and hold time for one segment position.
module tbbs_seg_dec import tbbs_pkg::*; (
	input  logic [SEG_IDX_W-1:0]     seg_idx,
	input  logic [BITS_PER_BYTE-1:0] data_byte,
	output seg_t                     seg
);

	logic [SEG_IDX_W-1:0] bit_pos;
	logic                 bit_val;

	// bit_pos[0] picks clock phase, bit_pos[3:1] counts bits from the MSB
	assign bit_pos = seg_idx - SEG_BIT_FIRST;
	assign bit_val = data_byte[3'(BITS_PER_BYTE - 1) - bit_pos[3:1]];

	always_comb begin
		unique case (seg_idx) inside
			SEG_START_IDLE: seg = '{1'b1, 1'b1, IDLE_UNITS};
			SEG_START_DATA: seg = '{1'b1, 1'b0, UNIT_ONE};
			SEG_START_CLK:  seg = '{1'b0, 1'b0, UNIT_ONE};
			[SEG_BIT_FIRST:SEG_BIT_LAST]: seg = '{bit_pos[0], bit_val, UNIT_ONE};
			SEG_STOP_LOW:   seg = '{1'b0, 1'b1, STOP_UNITS};
			SEG_STOP_HIGH:  seg = '{1'b1, 1'b1, UNIT_ONE};
			SEG_END_LOW:    seg = '{1'b0, 1'b0, UNIT_ONE};
			SEG_END_CLK:    seg = '{1'b1, 1'b0, UNIT_ONE};
			SEG_END_IDLE:   seg = '{1'b1, 1'b1, HOLD_FINAL};
			default:        seg = '{1'b1, 1'b1, HOLD_FINAL};
		endcase
	end

endmodule

@@ sim/serial_segment_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the line segments of each accepted byte and compares the output stream.
module serial_segment_checker import tbbs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [BITS_PER_BYTE-1:0] data_byte,
	input  logic                     end_of_message,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     clock_level,
	input  logic                     data_level,
	input  logic [HOLD_W-1:0]        hold_units,
	input  logic                     last_segment,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		seg_t seg;
		logic last;
	} line_seg_t;

	line_seg_t segs_due[$];
	line_seg_t want;
	logic      msg_open;

	function automatic void add_seg(input logic c, input logic d, input logic [HOLD_W-1:0] h);
		line_seg_t s;
		s.seg.clock_level = c;
		s.seg.data_level  = d;
		s.seg.hold_units  = h;
		s.last            = 1'b0;
		segs_due.push_back(s);
	endfunction

	// Expand one byte into its segments; the start sequence only opens a message.
	function automatic void predict_segments(input logic [BITS_PER_BYTE-1:0] b, input logic eom);
		line_seg_t tail;
		if (!msg_open) begin
			add_seg(1'b1, 1'b1, IDLE_UNITS);
			add_seg(1'b1, 1'b0, UNIT_ONE);
			add_seg(1'b0, 1'b0, UNIT_ONE);
			msg_open = 1'b1;
		end
		for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
			add_seg(1'b0, b[i], UNIT_ONE);
			add_seg(1'b1, b[i], UNIT_ONE);
		end
		add_seg(1'b0, 1'b1, STOP_UNITS);
		add_seg(1'b1, 1'b1, UNIT_ONE);
		if (eom) begin
			add_seg(1'b0, 1'b0, UNIT_ONE);
			add_seg(1'b1, 1'b0, UNIT_ONE);
			add_seg(1'b1, 1'b1, HOLD_FINAL);
			msg_open = 1'b0;
		end
		// mark the final segment of this byte
		tail = segs_due.pop_back();
		tail.last = 1'b1;
		segs_due.push_back(tail);
	endfunction

	function automatic void check_field(input string name, input logic [HOLD_W-1:0] exp_v,
			input logic [HOLD_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs_due.delete();
			msg_open   = 1'b0;
			fail_count = 0;
			pending    = 0;
		end else begin
			// an output transaction can never come from an input taken at the same edge
			if (out_valid && !out_stall) begin
				if (segs_due.size() == 0) begin
					$display("%0t: unexpected segment, expected none, got clk=%0b dat=%0b hold=%0d last=%0b",
						$time, clock_level, data_level, hold_units, last_segment);
					fail_count++;
				end else begin
					want = segs_due.pop_front();
					check_field("clock_level", HOLD_W'(want.seg.clock_level), HOLD_W'(clock_level));
					check_field("data_level", HOLD_W'(want.seg.data_level), HOLD_W'(data_level));
					check_field("hold_units", want.seg.hold_units, hold_units);
					check_field("last_segment", HOLD_W'(want.last), HOLD_W'(last_segment));
				end
			end
			if (in_valid && !in_stall)
				predict_segments(data_byte, end_of_message);
			pending = segs_due.size();
		end
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, byte stimulus, output stalls, watchdog and verdict.
module tb;
	import tbbs_pkg::*;

	localparam int ITEM_COUNT     = 220;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic [BITS_PER_BYTE-1:0] data_byte      = '0;
	logic                     end_of_message = 1'b0;
	logic                     out_stall      = 1'b0;
	logic                     in_stall;
	logic                     out_valid;
	logic                     clock_level;
	logic                     data_level;
	logic [HOLD_W-1:0]        hold_units;
	logic                     last_segment;

	int       fail_count;
	int       pending;
	int       idle_cycles = 0;
	int       bytes_sent  = 0;
	int       burst_left  = 0;
	rx_mode_t rx_mode     = RX_FREE;
	int       rx_run      = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	two_wire_bit_bang_serializer i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_stall(out_stall),
		.clock_level(clock_level), .data_level(data_level),
		.hold_units(hold_units), .last_segment(last_segment)
	);

	serial_segment_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_message(end_of_message),
		.out_valid(out_valid), .out_stall(out_stall),
		.clock_level(clock_level), .data_level(data_level),
		.hold_units(hold_units), .last_segment(last_segment),
		.fail_count(fail_count), .pending(pending)
	);

	// Hold the byte until accepted, then either stay in the burst or drop valid for a gap.
	task automatic send_byte(input logic [BITS_PER_BYTE-1:0] b, input logic eom);
		data_byte      <= b;
		end_of_message <= eom;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Receiver stalls in runs of differing density, including runs with no stall at all.
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_run  = (rx_mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(5, 60);
		end else begin
			rx_run--;
		end
		case (rx_mode)
			RX_FREE:  out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:  out_stall <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int                       msg_len;
		logic [BITS_PER_BYTE-1:0] b;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte messages at the extremes, then a longer message and a restart
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b1);
		send_byte(8'h3C, 1'b1);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain;

		while (bytes_sent < ITEM_COUNT) begin
			msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
			for (int k = 0; k < msg_len; k++) begin
				case ($urandom_range(0, 7))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					default: b = 8'($urandom);
				endcase
				send_byte(b, k == msg_len - 1);
			end
			if ($urandom_range(0, 7) == 0)
				drain;
		end

		drain;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending != 0)
			$display("%0t: %0d expected segments never arrived", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/tbbs_pkg.sv
hw/rtl/tbbs_seg_dec.sv
hw/rtl/two_wire_bit_bang_serializer.sv
sim/serial_segment_checker.sv
sim/tb.sv
